// ----- rtl/core/chi_pkg.sv -----
package chi_pkg;

    localparam int TIME_W    = 24;
    localparam int POS_W     = 32;
    localparam int MUL_CHUNK = 32;
    localparam int Q_BITS    = 33;

    typedef struct packed {
        logic [TIME_W-1:0]       elapsed;
        logic [TIME_W-1:0]       duration;
        logic signed [POS_W-1:0] start_pos;
        logic signed [POS_W-1:0] end_pos;
        logic signed [POS_W-1:0] start_vel;
        logic signed [POS_W-1:0] end_vel;
    } chi_in_t;

    typedef struct packed {
        logic signed [POS_W-1:0] position;
        logic                    bad_duration;
        logic                    saturated;
    } chi_out_t;

    typedef struct packed {
        logic signed [POS_W-1:0] position;
        logic                    saturated;
    } chi_res_t;

endpackage

// ----- rtl/core/chi_stream_if.sv -----
interface chi_stream_if #(parameter type T = logic);

    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);

endinterface

// ----- rtl/core/cubic_hermite_interpolator_top.sv -----
// Throughput: one item per cycle unless the output stalls; the 33-stage
// restoring divider and the chunked multiplier chain are fully pipelined.
// A stalled output holds the whole pipeline until the result transfers.
// Reset clears only the valid bits; data registers are not reset.
module cubic_hermite_interpolator_top import chi_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    chi_stream_if.sink   sample,
    chi_stream_if.source result
);

    localparam int TW  = TIME_W;
    localparam int PW  = POS_W;
    localparam int MX  = (FRAC_BITS > TW) ? FRAC_BITS : TW;
    localparam int HW  = PW + MX + 1;
    localparam int CW  = PW + MX + 4;
    localparam int GW  = CW + TW + 1;
    localparam int NW  = GW + 2 * TW + 1;
    localparam int RW  = NW + 1;
    localparam int DW  = 3 * TW + FRAC_BITS;
    localparam int TOT = 13 + Q_BITS + 2;

    logic               en;
    logic [TOT:0]       vld_reg;
    logic [TW-1:0]      t_line_reg [10];
    logic [TW-1:0]      d_line_reg [8];
    logic signed [PW-1:0] p0_reg, p1_reg, v0_reg, v1_reg;
    logic signed [PW:0]   dp_reg;
    logic signed [PW+1:0] s1_reg;
    logic signed [PW:0]   s2_reg;
    logic [PW:0]          dp3_u;
    logic signed [PW:0]   dp3;
    logic [PW-1:0]        p02_u;
    logic signed [PW+TW-1:0]   vt;
    logic signed [2*TW:0]      dd;
    logic signed [3*TW:0]      ddd;
    logic signed [PW+TW+1:0]   ds1;
    logic signed [PW+TW:0]     ds2;
    logic signed [HW-1:0]      h_reg;
    logic signed [CW-1:0]      c_reg, e_reg, c3;
    logic signed [HW+TW-1:0]   hd;
    logic signed [HW+2*TW-1:0] hdd;
    logic signed [HW+3*TW-1:0] hddd;
    logic [HW+3*TW-1:0]        hddd11_u;
    logic signed [CW+TW-1:0]   cd, et;
    logic signed [GW-1:0]      g_reg;
    logic signed [GW+TW-1:0]   gt;
    logic signed [GW+2*TW-1:0] gtt;
    logic signed [NW-1:0]      num_reg;
    logic [NW-1:0]             abs_num;
    logic [RW-1:0]             mag_reg;
    logic                      neg_reg;
    logic [DW-1:0]             den4, den13;
    logic [PW:0]               tail;
    chi_res_t                  div_res;

    assign en = !vld_reg[TOT] || result.ready;
    assign sample.ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[TOT-1:0], sample.valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t_line_reg[0] <= sample.data.elapsed;
            d_line_reg[0] <= sample.data.duration;
            for (int i = 1; i < 10; i++)
            begin
                t_line_reg[i] <= t_line_reg[i-1];
            end
            for (int i = 1; i < 8; i++)
            begin
                d_line_reg[i] <= d_line_reg[i-1];
            end
            p0_reg <= sample.data.start_pos;
            p1_reg <= sample.data.end_pos;
            v0_reg <= sample.data.start_vel;
            v1_reg <= sample.data.end_vel;
            dp_reg <= (PW+1)'(p1_reg) - (PW+1)'(p0_reg);
            s1_reg <= ((PW+2)'(v0_reg) <<< 1) + (PW+2)'(v1_reg);
            s2_reg <= (PW+1)'(v0_reg) + (PW+1)'(v1_reg);
            h_reg  <= (HW'($signed(p02_u)) <<< FRAC_BITS) + HW'(vt);
            c_reg  <= (c3 <<< FRAC_BITS) - CW'(ds1);
            e_reg  <= CW'(ds2) - (CW'(dp3) <<< (FRAC_BITS + 1));
            g_reg  <= GW'(cd) + GW'(et);
            num_reg <= NW'(gtt) + NW'($signed(hddd11_u));
            neg_reg <= num_reg[NW-1];
            mag_reg <= RW'(abs_num);
        end
    end

    assign dp3     = $signed(dp3_u);
    assign c3      = CW'(dp3) + (CW'(dp3) <<< 1);
    assign abs_num = num_reg[NW-1] ? NW'(-num_reg) : NW'(num_reg);
    assign den4    = {ddd[3*TW-1:0], {FRAC_BITS{1'b0}}};

    chi_dly #(.W(PW), .N(2)) u_p0_dly (
        .clk(clk), .en(en), .d(p0_reg), .q(p02_u));
    chi_dly #(.W(PW+1), .N(2)) u_dp_dly (
        .clk(clk), .en(en), .d(dp_reg), .q(dp3_u));
    chi_dly #(.W(HW+3*TW), .N(2)) u_hddd_dly (
        .clk(clk), .en(en), .d(hddd), .q(hddd11_u));
    chi_dly #(.W(DW), .N(9)) u_den_dly (
        .clk(clk), .en(en), .d(den4), .q(den13));
    chi_dly #(.W(PW+1), .N(TOT)) u_tail_dly (
        .clk(clk), .en(en), .d({d_line_reg[0] == '0, p0_reg}), .q(tail));

    chi_mul #(.WA(PW), .WB(TW)) u_vt (
        .clk(clk), .en(en), .a(v0_reg), .b(t_line_reg[0]), .p(vt));
    chi_mul #(.WA(TW+1), .WB(TW)) u_dd (
        .clk(clk), .en(en), .a($signed({1'b0, d_line_reg[0]})), .b(d_line_reg[0]),
        .p(dd));
    chi_mul #(.WA(2*TW+1), .WB(TW)) u_ddd (
        .clk(clk), .en(en), .a(dd), .b(d_line_reg[2]), .p(ddd));
    chi_mul #(.WA(PW+2), .WB(TW)) u_ds1 (
        .clk(clk), .en(en), .a(s1_reg), .b(d_line_reg[1]), .p(ds1));
    chi_mul #(.WA(PW+1), .WB(TW)) u_ds2 (
        .clk(clk), .en(en), .a(s2_reg), .b(d_line_reg[1]), .p(ds2));
    chi_mul #(.WA(HW), .WB(TW)) u_hd (
        .clk(clk), .en(en), .a(h_reg), .b(d_line_reg[3]), .p(hd));
    chi_mul #(.WA(HW+TW), .WB(TW)) u_hdd (
        .clk(clk), .en(en), .a(hd), .b(d_line_reg[5]), .p(hdd));
    chi_mul #(.WA(HW+2*TW), .WB(TW)) u_hddd (
        .clk(clk), .en(en), .a(hdd), .b(d_line_reg[7]), .p(hddd));
    chi_mul #(.WA(CW), .WB(TW)) u_cd (
        .clk(clk), .en(en), .a(c_reg), .b(d_line_reg[4]), .p(cd));
    chi_mul #(.WA(CW), .WB(TW)) u_et (
        .clk(clk), .en(en), .a(e_reg), .b(t_line_reg[4]), .p(et));
    chi_mul #(.WA(GW), .WB(TW)) u_gt (
        .clk(clk), .en(en), .a(g_reg), .b(t_line_reg[7]), .p(gt));
    chi_mul #(.WA(GW+TW), .WB(TW)) u_gtt (
        .clk(clk), .en(en), .a(gt), .b(t_line_reg[9]), .p(gtt));

    chi_div #(.RW(RW), .DW(DW)) u_div (
        .clk(clk), .en(en), .mag(mag_reg), .neg(neg_reg), .den(den13), .res(div_res));

    assign result.valid             = vld_reg[TOT];
    assign result.data.bad_duration = tail[PW];
    assign result.data.position     = tail[PW] ? $signed(tail[PW-1:0]) : div_res.position;
    assign result.data.saturated    = !tail[PW] && div_res.saturated;

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && !result.ready |=> result.valid)
        else $error("result dropped during stall");

    a_bad_nosat: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.data.bad_duration |-> !result.data.saturated)
        else $error("bad duration flagged as saturated");

    a_sat_rail: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.data.saturated |->
            (result.data.position == {1'b0, {(PW-1){1'b1}}}) ||
            (result.data.position == {1'b1, {(PW-1){1'b0}}}))
        else $error("saturated result not at a rail");

endmodule

// ----- rtl/core/chi_dly.sv -----
module chi_dly #(
    parameter int W = 8,
    parameter int N = 1
) (
    input  logic         clk,
    input  logic         en,
    input  logic [W-1:0] d,
    output logic [W-1:0] q
);

    logic [W-1:0] line_reg [N];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            line_reg[0] <= d;
            for (int i = 1; i < N; i++)
            begin
                line_reg[i] <= line_reg[i-1];
            end
        end
    end

    assign q = line_reg[N-1];

endmodule

// ----- rtl/core/chi_mul.sv -----
module chi_mul import chi_pkg::*; #(
    parameter int WA = 32,
    parameter int WB = 24
) (
    input  logic                    clk,
    input  logic                    en,
    input  logic signed [WA-1:0]    a,
    input  logic [WB-1:0]           b,
    output logic signed [WA+WB-1:0] p
);

    localparam int NC  = (WA + MUL_CHUNK - 1) / MUL_CHUNK;
    localparam int AW  = NC * MUL_CHUNK;
    localparam int PPW = MUL_CHUNK + WB + 2;
    localparam int SW  = AW + WB + 2;

    logic signed [AW-1:0]    a_ext;
    logic signed [PPW-1:0]   pp_reg [NC];
    logic signed [SW-1:0]    sum;
    logic signed [WA+WB-1:0] p_reg;

    assign a_ext = AW'(a);

    for (genvar i = 0; i < NC; i++)
    begin : g_pp
        logic signed [MUL_CHUNK:0] chunk;
        if (i == NC - 1)
        begin : g_top
            assign chunk = {a_ext[AW-1], a_ext[i*MUL_CHUNK +: MUL_CHUNK]};
        end
        else
        begin : g_low
            assign chunk = {1'b0, a_ext[i*MUL_CHUNK +: MUL_CHUNK]};
        end
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                pp_reg[i] <= chunk * $signed({1'b0, b});
            end
        end
    end

    always_comb
    begin
        sum = '0;
        for (int i = 0; i < NC; i++)
        begin
            sum = sum + (SW'(pp_reg[i]) <<< (i * MUL_CHUNK));
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg <= sum[WA+WB-1:0];
        end
    end

    assign p = p_reg;

endmodule

// ----- rtl/core/chi_div.sv -----
module chi_div import chi_pkg::*; #(
    parameter int RW = 136,
    parameter int DW = 88
) (
    input  logic          clk,
    input  logic          en,
    input  logic [RW-1:0] mag,
    input  logic          neg,
    input  logic [DW-1:0] den,
    output chi_res_t      res
);

    logic [RW-1:0]     rem_reg [Q_BITS+1];
    logic [DW-1:0]     den_reg [Q_BITS+1];
    logic [Q_BITS-1:0] q_reg   [Q_BITS+1];
    logic              neg_reg [Q_BITS+1];
    logic              ovf_reg [Q_BITS+1];
    logic [RW:0]       ovf_lim;
    chi_res_t          res_next;
    chi_res_t          res_reg;
    logic              rnd;
    logic [Q_BITS:0]   qr;
    logic [Q_BITS:0]   limit;
    logic [POS_W-1:0]  qmag;

    assign ovf_lim = (RW+1)'(den) << Q_BITS;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= mag;
            den_reg[0] <= den;
            q_reg[0]   <= '0;
            neg_reg[0] <= neg;
            ovf_reg[0] <= {1'b0, mag} >= ovf_lim;
        end
    end

    for (genvar i = 1; i <= Q_BITS; i++)
    begin : g_bit
        localparam int K = Q_BITS - i;
        logic [RW:0]       trial;
        logic              take;
        logic [Q_BITS-1:0] q_next;
        assign trial = {1'b0, rem_reg[i-1]} - ((RW+1)'(den_reg[i-1]) << K);
        assign take  = !trial[RW];
        always_comb
        begin
            q_next    = q_reg[i-1];
            q_next[K] = take;
        end
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[i] <= take ? trial[RW-1:0] : rem_reg[i-1];
                den_reg[i] <= den_reg[i-1];
                q_reg[i]   <= q_next;
                neg_reg[i] <= neg_reg[i-1];
                ovf_reg[i] <= ovf_reg[i-1];
            end
        end
    end

    always_comb
    begin
        rnd   = {rem_reg[Q_BITS], 1'b0} >= (RW+1)'(den_reg[Q_BITS]);
        qr    = (Q_BITS+1)'(q_reg[Q_BITS]) + (Q_BITS+1)'(rnd);
        limit = neg_reg[Q_BITS] ? ((Q_BITS+1)'(1) << (POS_W-1))
                                : (((Q_BITS+1)'(1) << (POS_W-1)) - 1'b1);
        qmag  = qr[POS_W-1:0];
        res_next.saturated = ovf_reg[Q_BITS] || (qr > limit);
        if (res_next.saturated)
        begin
            res_next.position = neg_reg[Q_BITS] ? {1'b1, {(POS_W-1){1'b0}}}
                                                : {1'b0, {(POS_W-1){1'b1}}};
        end
        else
        begin
            res_next.position = neg_reg[Q_BITS] ? $signed(-qmag) : $signed(qmag);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            res_reg <= res_next;
        end
    end

    assign res = res_reg;

endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top import chi_pkg::*; ();

    localparam int FRAC       = 16;
    localparam int LATENCY    = 48;
    localparam int WDOG_LIMIT = 4000;
    localparam int HOLD_START = 1500;
    localparam int HOLD_LEN   = 300;
    localparam int CALM_START = 300;
    localparam int CALM_END   = 800;

    logic clk;
    logic rst_n;

    chi_stream_if #(.T(chi_in_t))  sample_if ();
    chi_stream_if #(.T(chi_out_t)) result_if ();

    cubic_hermite_interpolator_top #(.FRAC_BITS(FRAC)) u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .sample (sample_if),
        .result (result_if)
    );

    chi_in_t  segment_q[$];
    chi_out_t position_q[$];
    int       cycle_cnt;
    int       errors = 0;
    int       quiet_cycles = 0;

    initial
    begin
        clk = 1'b0;
    end

    always #4 clk = ~clk;

    function automatic chi_out_t hermite_position(chi_in_t x);
        logic signed [191:0] t, d, p0, p1, v0, v1, sc, c3, c2, num, den;
        logic [191:0]        mag, uden, q, r, lim;
        logic                neg, sat;
        chi_out_t            o;
        o = '0;
        if (x.duration == '0)
        begin
            o.position     = x.start_pos;
            o.bad_duration = 1'b1;
            return o;
        end
        t   = x.elapsed;
        d   = x.duration;
        p0  = x.start_pos;
        p1  = x.end_pos;
        v0  = x.start_vel;
        v1  = x.end_vel;
        sc  = 192'sd1 <<< FRAC;
        c3  = 3 * (p1 - p0) * sc - d * (2 * v0 + v1);
        c2  = 2 * (p0 - p1) * sc + d * (v0 + v1);
        num = p0 * sc * d * d * d + v0 * t * d * d * d + c3 * t * t * d + c2 * t * t * t;
        den = sc * d * d * d;
        neg  = num < 0;
        mag  = neg ? -num : num;
        uden = den;
        q    = mag / uden;
        r    = mag - q * uden;
        if ((r << 1) >= uden)
            q = q + 1;
        lim = neg ? 192'h8000_0000 : 192'h7FFF_FFFF;
        sat = q > lim;
        if (sat)
            o.position = neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
        else
            o.position = neg ? -q[31:0] : q[31:0];
        o.saturated = sat;
        return o;
    endfunction

    function automatic chi_in_t make_segment(logic [23:0] t, logic [23:0] d,
                                             logic [31:0] p0, logic [31:0] p1,
                                             logic [31:0] v0, logic [31:0] v1);
        chi_in_t s;
        s.elapsed   = t;
        s.duration  = d;
        s.start_pos = p0;
        s.end_pos   = p1;
        s.start_vel = v0;
        s.end_vel   = v1;
        return s;
    endfunction

    function automatic logic [31:0] rand_signed(int unsigned span);
        return $urandom_range(2 * span, 0) - span;
    endfunction

    function automatic chi_in_t random_segment();
        logic [23:0] d;
        logic [23:0] t;
        int          pick;
        pick = $urandom_range(99, 0);
        if (pick < 20)
        begin
            d = ($urandom_range(9, 0) == 0) ? 24'd0 : 24'($urandom());
            return make_segment(24'($urandom()), d, $urandom(), $urandom(), $urandom(),
                                $urandom());
        end
        d = 24'($urandom_range(24'h3FFFF, 1));
        if (pick < 85)
            t = 24'($urandom_range(d, 0));
        else
            t = 24'($urandom_range(d + d / 4, 0));
        return make_segment(t, d, rand_signed(1 << 24), rand_signed(1 << 24),
                            rand_signed(1 << 22), rand_signed(1 << 22));
    endfunction

    // sender: drive next transfer, record its expected position
    always @(posedge clk or negedge rst_n)
    begin
        logic    idle;
        logic    nxt_valid;
        chi_in_t nxt_data;
        if (!rst_n)
        begin
            sample_if.valid <= 1'b0;
            sample_if.data  <= '0;
        end
        else
        begin
            if (sample_if.valid && sample_if.ready)
                position_q.insert(position_q.size(), hermite_position(sample_if.data));
            if (!sample_if.valid || sample_if.ready)
            begin
                idle = (cycle_cnt < CALM_START || cycle_cnt > CALM_END) &&
                       ($urandom_range(99, 0) < 34);
                nxt_valid = 1'b0;
                nxt_data  = sample_if.data;
                if (!idle && segment_q.size() > 0)
                begin
                    nxt_valid = 1'b1;
                    nxt_data  = segment_q.pop_front();
                end
                sample_if.valid <= nxt_valid;
                sample_if.data  <= nxt_data;
            end
        end
    end

    // receiver: check each result; random stalls, a calm window, plus one long hold-off
    always @(posedge clk or negedge rst_n)
    begin
        chi_out_t want;
        logic     hold;
        if (!rst_n)
        begin
            result_if.ready <= 1'b0;
            cycle_cnt       <= 0;
        end
        else
        begin
            cycle_cnt <= cycle_cnt + 1;
            if (result_if.valid && result_if.ready)
            begin
                if (position_q.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result, expected none, actual %h", $time,
                             result_if.data);
                end
                else
                begin
                    want = position_q.pop_front();
                    if (result_if.data.position !== want.position)
                    begin
                        errors++;
                        $display("%0t: position expected %h actual %h", $time,
                                 want.position, result_if.data.position);
                    end
                    if (result_if.data.bad_duration !== want.bad_duration)
                    begin
                        errors++;
                        $display("%0t: bad_duration expected %b actual %b", $time,
                                 want.bad_duration, result_if.data.bad_duration);
                    end
                    if (result_if.data.saturated !== want.saturated)
                    begin
                        errors++;
                        $display("%0t: saturated expected %b actual %b", $time,
                                 want.saturated, result_if.data.saturated);
                    end
                end
            end
            if (cycle_cnt >= HOLD_START && cycle_cnt < HOLD_START + HOLD_LEN)
                hold = 1'b1;
            else if (cycle_cnt >= CALM_START && cycle_cnt <= CALM_END)
                hold = 1'b0;
            else
                hold = $urandom_range(99, 0) < 34;
            result_if.ready <= !hold;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (sample_if.valid && sample_if.ready) ||
            (result_if.valid && result_if.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WDOG_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;

        segment_q.insert(segment_q.size(), make_segment(24'h010000, 24'h000000,
                         32'h1234_5678, 32'h0, 32'h0, 32'h0));
        segment_q.insert(segment_q.size(), make_segment(24'hFFFFFF, 24'h000000,
                         32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000));
        segment_q.insert(segment_q.size(), make_segment(24'h000000, 24'h010000,
                         32'h0001_0000, 32'h0005_0000, 32'h0, 32'h0));
        segment_q.insert(segment_q.size(), make_segment(24'h008000, 24'h010000,
                         32'h0001_0000, 32'h0005_0000, 32'h0, 32'h0));
        segment_q.insert(segment_q.size(), make_segment(24'h010000, 24'h010000,
                         32'h0001_0000, 32'h0005_0000, 32'h0, 32'h0));
        segment_q.insert(segment_q.size(), make_segment(24'h030000, 24'h010000,
                         32'h0001_0000, 32'h0005_0000, 32'h0002_0000, 32'hFFFF_0000));
        segment_q.insert(segment_q.size(), make_segment(24'h000001, 24'h000001,
                         32'h0, 32'h1, 32'h0, 32'h0));
        segment_q.insert(segment_q.size(), make_segment(24'h000001, 24'h000003,
                         32'h0, 32'h1, 32'h0, 32'h0));
        segment_q.insert(segment_q.size(), make_segment(24'h000002, 24'h000003,
                         32'h0, 32'hFFFF_FFFF, 32'h0, 32'h0));
        segment_q.insert(segment_q.size(), make_segment(24'hFFFFFF, 24'hFFFFFF,
                         32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'h0));
        segment_q.insert(segment_q.size(), make_segment(24'h7FFFFF, 24'hFFFFFF,
                         32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
        segment_q.insert(segment_q.size(), make_segment(24'hFFFFFF, 24'h000001,
                         32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
        segment_q.insert(segment_q.size(), make_segment(24'hFFFFFF, 24'h000001,
                         32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
        segment_q.insert(segment_q.size(), make_segment(24'h020000, 24'h010000,
                         32'h7FFF_0000, 32'h7FFF_FFFF, 32'h0100_0000, 32'h0100_0000));
        segment_q.insert(segment_q.size(), make_segment(24'h020000, 24'h010000,
                         32'h8001_0000, 32'h8000_0000, 32'hFF00_0000, 32'hFF00_0000));
        segment_q.insert(segment_q.size(), make_segment(24'h000000, 24'hFFFFFF,
                         32'h8000_0000, 32'h0, 32'h0, 32'h0));
        segment_q.insert(segment_q.size(), make_segment(24'h000000, 24'h000001,
                         32'h7FFF_FFFF, 32'h0, 32'h8000_0000, 32'h7FFF_FFFF));
        segment_q.insert(segment_q.size(), make_segment(24'h800000, 24'h400000,
                         32'hFFFF_8000, 32'h0000_8000, 32'h0000_4000, 32'hFFFF_C000));
        segment_q.insert(segment_q.size(), make_segment(24'h5A5A5A, 24'hA5A5A5,
                         32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555));
        segment_q.insert(segment_q.size(), make_segment(24'hA5A5A5, 24'h5A5A5A,
                         32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA));
        for (int i = 0; i < 1130; i++)
            segment_q.insert(segment_q.size(), random_segment());

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        while (segment_q.size() > 0 || sample_if.valid || position_q.size() > 0)
            @(posedge clk);
        repeat (LATENCY + 20) @(posedge clk);

        if (errors == 0 && position_q.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
